### rtl/core/slc_pkg.sv
// Shared constants, beat types and the cell operation type for the sorted list engine.
package slc_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_INSERTED  = 3'd0;
    localparam logic [2:0] STAT_FULL      = 3'd1;
    localparam logic [2:0] STAT_REMOVED   = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [2:0] STAT_ELEMENT   = 3'd4;
    localparam logic [2:0] STAT_EMPTY     = 3'd5;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    typedef struct packed {
        logic [1:0] command;
        t_value     operand;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] status;
        t_value     item;
        logic       last;
    } t_out_beat;

    // What every cell does in the current cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

endpackage

### rtl/core/sorted_list_engine.sv
// Top level of the sorted list engine: control, occupancy, result register and cell chain.
//
//  channel  valid       stall        payload
//  input    i_in_valid  o_in_stall   i_in_data  (slc_pkg::t_in_beat)
//  output   o_out_valid i_out_stall  o_out_data (slc_pkg::t_out_beat)
//
// Insert and remove: every cell compares against the operand and
// shifts toward or away from its neighbor in the same clock.
// A dump is accepted, then emits one beat per stored value; the chain
// rotates one slot per emitted beat and is back in order after the last one.
// Synchronous active-low reset empties the table; the cell contents are not cleared.
// A stalled result holds the engine: no input is taken until the result slot frees.
module sorted_list_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  slc_pkg::t_in_beat i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output slc_pkg::t_out_beat o_out_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

    t_state                          r_state, n_state;
    logic [slc_pkg::COUNT_W-1:0]     r_count, n_count;
    logic [slc_pkg::COUNT_W-1:0]     r_dump_idx, n_dump_idx;
    logic                            r_out_valid, n_out_valid;
    slc_pkg::t_out_beat              r_out_data, n_out_data;

    slc_pkg::t_cell_op               cell_op;
    logic [slc_pkg::CAPACITY-1:0]    cell_lt;
    logic [slc_pkg::CAPACITY-1:0]    cell_hit;
    slc_pkg::t_value                 cell_value [slc_pkg::CAPACITY];

    logic out_free;
    logic accept;
    logic found;
    logic full;
    logic dump_emit;
    logic dump_last;

    // Handshake
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign found     = |cell_hit;
    assign full      = (r_count == slc_pkg::COUNT_W'(slc_pkg::CAPACITY));
    assign dump_emit = (r_state == S_DUMP) && out_free;
    assign dump_last = ((r_dump_idx + slc_pkg::COUNT_W'(1)) == r_count);

    // Chain operation for this cycle
    always_comb begin
        cell_op = slc_pkg::CELL_HOLD;
        if (accept) begin
            unique case (i_in_data.command)
                slc_pkg::CMD_INSERT: cell_op = full  ? slc_pkg::CELL_HOLD
                                                     : slc_pkg::CELL_INSERT;
                slc_pkg::CMD_REMOVE: cell_op = found ? slc_pkg::CELL_REMOVE
                                                     : slc_pkg::CELL_HOLD;
                default:             cell_op = slc_pkg::CELL_HOLD;
            endcase
        end else if (dump_emit) begin
            cell_op = slc_pkg::CELL_ROTATE;
        end
    end

    // Cell chain
    for (genvar g = 0; g < slc_pkg::CAPACITY; g++) begin : g_cell
        logic            prev_lt;
        slc_pkg::t_value prev_value;
        slc_pkg::t_value next_value;

        if (g == 0) begin : g_head
            assign prev_lt    = 1'b1;
            assign prev_value = cell_value[g];
        end else begin : g_body
            assign prev_lt    = cell_lt[g-1];
            assign prev_value = cell_value[g-1];
        end

        if (g == slc_pkg::CAPACITY - 1) begin : g_tail
            assign next_value = cell_value[g];
        end else begin : g_inner
            assign next_value = cell_value[g+1];
        end

        slc_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (cell_op),
            .i_operand    (i_in_data.operand),
            .i_occupied   (slc_pkg::COUNT_W'(g) < r_count),
            .i_prev_lt    (prev_lt),
            .i_prev_value (prev_value),
            .i_next_value (next_value),
            .i_head_value (cell_value[0]),
            .i_wrap       (slc_pkg::COUNT_W'(g + 1) == r_count),
            .o_lt         (cell_lt[g]),
            .o_hit        (cell_hit[g]),
            .o_value      (cell_value[g])
        );
    end

    // Control, occupancy and result beat
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dump_idx  = r_dump_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;

        if (accept) begin
            n_out_valid     = 1'b1;
            n_out_data.item = '0;
            n_out_data.last = 1'b1;
            unique case (i_in_data.command)
                slc_pkg::CMD_INSERT: begin
                    if (full) begin
                        n_out_data.status = slc_pkg::STAT_FULL;
                    end else begin
                        n_out_data.status = slc_pkg::STAT_INSERTED;
                        n_count           = r_count + slc_pkg::COUNT_W'(1);
                    end
                end
                slc_pkg::CMD_REMOVE: begin
                    if (found) begin
                        n_out_data.status = slc_pkg::STAT_REMOVED;
                        n_out_data.item   = i_in_data.operand;
                        n_count           = r_count - slc_pkg::COUNT_W'(1);
                    end else begin
                        n_out_data.status = slc_pkg::STAT_NOT_FOUND;
                    end
                end
                slc_pkg::CMD_DUMP: begin
                    if (r_count == '0) begin
                        n_out_data.status = slc_pkg::STAT_EMPTY;
                    end else begin
                        n_out_valid = 1'b0;
                        n_state     = S_DUMP;
                        n_dump_idx  = '0;
                    end
                end
                default: begin
                    n_out_valid = 1'b0;
                end
            endcase
        end else if (dump_emit) begin
            n_out_valid       = 1'b1;
            n_out_data.status = slc_pkg::STAT_ELEMENT;
            n_out_data.item   = cell_value[0];
            n_out_data.last   = dump_last;
            n_dump_idx        = r_dump_idx + slc_pkg::COUNT_W'(1);
            if (dump_last) begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dump_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dump_idx  <= n_dump_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

endmodule

### rtl/core/slc_cell.sv
// One slot of the sorted chain: holds a value, compares it, shifts with its neighbors.
module slc_cell (
    input  logic               i_clk,
    input  slc_pkg::t_cell_op  i_op,
    input  slc_pkg::t_value    i_operand,
    input  logic               i_occupied,
    input  logic               i_prev_lt,
    input  slc_pkg::t_value    i_prev_value,
    input  slc_pkg::t_value    i_next_value,
    input  slc_pkg::t_value    i_head_value,
    input  logic               i_wrap,
    output logic               o_lt,
    output logic               o_hit,
    output slc_pkg::t_value    o_value
);

    slc_pkg::t_value r_value;
    slc_pkg::t_value n_value;

    // Compare: occupied slots below the operand stay put
    assign o_lt    = i_occupied && (r_value < i_operand);
    // First slot not below the operand holds an equal value
    assign o_hit   = i_occupied && i_prev_lt && !o_lt && (r_value == i_operand);
    assign o_value = r_value;

    // Next value from the chain
    always_comb begin
        n_value = r_value;
        unique case (i_op)
            slc_pkg::CELL_HOLD: begin
                n_value = r_value;
            end
            slc_pkg::CELL_INSERT: begin
                if (!o_lt) begin
                    n_value = i_prev_lt ? i_operand : i_prev_value;
                end
            end
            slc_pkg::CELL_REMOVE: begin
                if (!o_lt) begin
                    n_value = i_next_value;
                end
            end
            slc_pkg::CELL_ROTATE: begin
                n_value = i_wrap ? i_head_value : i_next_value;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

### dv/slc_checker.sv
// Checker for the sorted list engine: watches both channels, predicts and compares beats.
`timescale 1ns / 100ps
module slc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  slc_pkg::t_in_beat  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  slc_pkg::t_out_beat i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_item_count,
    output int                 o_result_count,
    output int                 o_full_count
);

    // Shadow copy of the sorted table
    slc_pkg::t_value    sorted_vals [slc_pkg::CAPACITY];
    int                 stored_count;
    // Result beats still owed by the engine, oldest first
    slc_pkg::t_out_beat owed_beats [$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_item_count   = 0;
        o_result_count = 0;
        o_full_count   = 0;
        stored_count   = 0;
    end

    // One line per mismatch, and the count
    task automatic report_mismatch(input string text);
        $display("%0t ns  mismatch: %s", $time, text);
        o_fail_count++;
    endtask

    task automatic owe_beat(input logic [2:0] status, input slc_pkg::t_value item,
                            input logic last);
        slc_pkg::t_out_beat beat;
        beat.status = status;
        beat.item   = item;
        beat.last   = last;
        owed_beats.push_back(beat);
    endtask

    // Apply one command to the shadow table and queue the beats it should produce
    task automatic predict_results(input slc_pkg::t_in_beat cmd_beat);
        slc_pkg::t_value val;
        int              pos;
        int              hit;
        val = cmd_beat.operand;
        case (cmd_beat.command)
            slc_pkg::CMD_INSERT: begin
                if (stored_count >= slc_pkg::CAPACITY) begin
                    owe_beat(slc_pkg::STAT_FULL, '0, 1'b1);
                    o_full_count++;
                end else begin
                    // land before the first value that is not smaller
                    pos = 0;
                    while (pos < stored_count && sorted_vals[pos] < val)
                        pos++;
                    for (int k = stored_count; k > pos; k--)
                        sorted_vals[k] = sorted_vals[k-1];
                    sorted_vals[pos] = val;
                    stored_count++;
                    owe_beat(slc_pkg::STAT_INSERTED, '0, 1'b1);
                end
            end
            slc_pkg::CMD_REMOVE: begin
                hit = -1;
                for (int k = 0; k < stored_count; k++)
                    if (hit < 0 && sorted_vals[k] == val)
                        hit = k;
                if (hit < 0) begin
                    owe_beat(slc_pkg::STAT_NOT_FOUND, '0, 1'b1);
                end else begin
                    for (int k = hit; k + 1 < stored_count; k++)
                        sorted_vals[k] = sorted_vals[k+1];
                    stored_count--;
                    owe_beat(slc_pkg::STAT_REMOVED, val, 1'b1);
                end
            end
            slc_pkg::CMD_DUMP: begin
                if (stored_count == 0)
                    owe_beat(slc_pkg::STAT_EMPTY, '0, 1'b1);
                else
                    for (int k = 0; k < stored_count; k++)
                        owe_beat(slc_pkg::STAT_ELEMENT, sorted_vals[k],
                                 k == stored_count - 1);
            end
            default: begin
                // unused command code: no beat, no change
            end
        endcase
    endtask

    // Result side is checked before the input side; results come from a register
    always @(posedge i_clk) begin
        slc_pkg::t_out_beat want;
        if (!i_rst_n) begin
            stored_count = 0;
            owed_beats.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_result_count++;
                if (owed_beats.size() == 0) begin
                    report_mismatch($sformatf("result beat status %0d item %0d with nothing owed",
                                              i_out_data.status, i_out_data.item));
                end else begin
                    want = owed_beats.pop_front();
                    if (i_out_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_out_data.status, want.status));
                    if (i_out_data.item !== want.item)
                        report_mismatch($sformatf("item %0d, expected %0d",
                                                  i_out_data.item, want.item));
                    if (i_out_data.last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  i_out_data.last, want.last));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                o_item_count++;
                predict_results(i_in_data);
            end
        end
        o_pending = owed_beats.size();
    end

endmodule

### dv/tb_top.sv
// Testbench top for the sorted list engine: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_top;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RUN_LIMIT   = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 15;
    localparam int POOL_MAX    = 32;
    localparam int TAIL_CYCLES = 24;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    slc_pkg::t_in_beat  in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    slc_pkg::t_out_beat out_data;

    int fail_count;
    int pending;
    int item_count;
    int result_count;
    int full_count;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int cycle_count    = 0;

    // Values recently inserted, so that removes mostly hit
    slc_pkg::t_value insert_pool [$];

    always #5 clk = ~clk;

    sorted_list_engine i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    slc_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_data     (out_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_item_count   (item_count),
        .o_result_count (result_count),
        .o_full_count   (full_count)
    );

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d result beats still owed",
                     cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side flow control: random stall, or a long hold when requested
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_request != hold_seen) begin
                hold_seen = hold_request;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else begin
                out_stall = ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Offer one beat after random idle cycles; returns at the falling edge after acceptance
    task automatic send_beat(input logic [1:0] cmd, input slc_pkg::t_value val);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_data.command = cmd;
        in_data.operand = val;
        in_valid        = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Drop valid and wait at falling edges until every owed result beat has come back
    task automatic drain_results();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Operands: extremes, a narrow band for duplicates and hits, or anything
    function automatic slc_pkg::t_value pick_operand();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            case ($urandom_range(5))
                0:       return {1'b1, {(slc_pkg::VALUE_WIDTH-1){1'b0}}};
                1:       return {1'b0, {(slc_pkg::VALUE_WIDTH-1){1'b1}}};
                2:       return '0;
                3:       return '1;
                4:       return {1'b1, {(slc_pkg::VALUE_WIDTH-2){1'b0}}, 1'b1};
                default: return {1'b0, {(slc_pkg::VALUE_WIDTH-2){1'b1}}, 1'b0};
            endcase
        end
        if (sel < 70)
            return slc_pkg::t_value'($signed($urandom_range(16)) - 8);
        return slc_pkg::t_value'($urandom);
    endfunction

    // Random commands; unused codes are thrown in but not counted
    task automatic run_random(input int count);
        int              done;
        int              roll;
        int              idx;
        slc_pkg::t_value val;
        done = 0;
        while (done < count) begin
            roll = $urandom_range(99);
            if (roll < 3) begin
                send_beat(CMD_UNUSED, slc_pkg::t_value'($urandom));
            end else if (roll < 52) begin
                val = pick_operand();
                insert_pool.push_back(val);
                if (insert_pool.size() > POOL_MAX)
                    void'(insert_pool.pop_front());
                send_beat(slc_pkg::CMD_INSERT, val);
                done++;
            end else if (roll < 84) begin
                if (insert_pool.size() > 0 && $urandom_range(99) < 75) begin
                    idx = $urandom_range(insert_pool.size() - 1);
                    val = insert_pool[idx];
                    insert_pool.delete(idx);
                end else begin
                    val = pick_operand();
                end
                send_beat(slc_pkg::CMD_REMOVE, val);
                done++;
            end else begin
                send_beat(slc_pkg::CMD_DUMP, slc_pkg::t_value'($urandom));
                done++;
            end
        end
    endtask

    // Stimulus and verdict
    initial begin
        slc_pkg::t_value fill_vals [16];
        slc_pkg::t_value v_min;
        slc_pkg::t_value v_max;
        v_min = {1'b1, {(slc_pkg::VALUE_WIDTH-1){1'b0}}};
        v_max = {1'b0, {(slc_pkg::VALUE_WIDTH-1){1'b1}}};
        fill_vals = '{v_max, v_min, 0, -1, 0, 1, v_min + 1, v_max - 1,
                      -8, 7, 7, 3, -3, 100, -100, 42};

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, unused code, fill to capacity, refusal, removes, dumps
        send_beat(slc_pkg::CMD_DUMP, '1);
        send_beat(slc_pkg::CMD_REMOVE, 5);
        send_beat(CMD_UNUSED, '1);
        foreach (fill_vals[k])
            send_beat(slc_pkg::CMD_INSERT, fill_vals[k]);
        send_beat(slc_pkg::CMD_INSERT, 9);
        send_beat(slc_pkg::CMD_DUMP, '0);
        send_beat(slc_pkg::CMD_REMOVE, v_max);
        send_beat(slc_pkg::CMD_REMOVE, v_min);
        send_beat(slc_pkg::CMD_REMOVE, 55);
        send_beat(slc_pkg::CMD_REMOVE, 0);
        send_beat(slc_pkg::CMD_DUMP, '0);

        // Random phases with different idling on each side
        run_random(PHASE_ITEMS);
        send_idle_pct  = 55;
        run_random(PHASE_ITEMS);
        send_idle_pct  = 0;
        recv_stall_pct = 55;
        run_random(PHASE_ITEMS);
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        run_random(PHASE_ITEMS);

        // Long hold on the result side while commands keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        in_valid = 1'b0;
        @(posedge clk);
        hold_request++;
        @(negedge clk);
        run_random(8);

        // Sender pauses until the engine has returned everything, then resumes
        drain_results();
        recv_stall_pct = 30;
        run_random(4);

        in_valid = 1'b0;
        recv_stall_pct = 0;
        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("run covered %0d accepted commands and %0d compared result beats",
                 item_count, result_count);
        $display("full-table refusals: %0d; idling on each side, a long result hold and a drain",
                 full_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sorted_list_engine.f
rtl/core/slc_pkg.sv
rtl/core/slc_cell.sv
rtl/core/sorted_list_engine.sv
dv/slc_checker.sv
dv/tb_top.sv
